[hw/rtl/cwfe_pkg.sv]
// shared types and constants for the connection window feature extractor
`timescale 1ns / 1ps
package cwfe_pkg;

    localparam int unsigned DEPTH_DEFAULT = 128;
    localparam logic [31:0] WINDOW_RESET  = 32'd2000;
    localparam int unsigned FEATURE_COUNT = 19;
    localparam logic [16:0] Q_ONE         = 17'd32768;

    // flag codes used by the error counters
    localparam logic [3:0] FLAG_REJ = 4'd1;
    localparam logic [3:0] FLAG_S0  = 4'd5;
    localparam logic [3:0] FLAG_S3  = 4'd8;

    // one connection record
    typedef struct packed {
        logic [31:0] timestamp;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [7:0]  service_id;
        logic [3:0]  flag_code;
    } rec_t;

    // one feature result
    typedef struct packed {
        logic [4:0]  feature_index;
        logic [15:0] feature_value;
        logic        last;
    } feat_t;

    // the sixteen scan counters (each fits DEPTH up to 1024)
    typedef struct packed {
        logic [10:0] cnt;
        logic [10:0] srv;
        logic [10:0] host_srv;
        logic [10:0] srv_diff;
        logic [10:0] c_se;
        logic [10:0] c_re;
        logic [10:0] s_se;
        logic [10:0] s_re;
        logic [10:0] h_cnt;
        logic [10:0] h_srv;
        logic [10:0] h_port;
        logic [10:0] h_diff;
        logic [10:0] h_se;
        logic [10:0] h_re;
        logic [10:0] hs_se;
        logic [10:0] hs_re;
    } counts_t;

endpackage

[hw/rtl/cwfe_scan.sv]
// front part: record ring memory and newest-to-oldest scan that builds the counters
`timescale 1ns / 1ps
module cwfe_scan #(
    parameter int unsigned DEPTH = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       window_length,
    input  logic              rec_valid,
    output logic              rec_ready,
    input  cwfe_pkg::rec_t    rec,
    output logic              cnt_valid,
    input  logic              cnt_ready,
    output cwfe_pkg::counts_t cnt_out
);
    import cwfe_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_READ, S_ACC, S_STORE, S_HOLD} state_t;

    rec_t               ring_mem [DEPTH];
    rec_t               ent_reg;
    state_t             state_reg;
    rec_t               cur_reg;
    logic [AW-1:0]      wp_reg;
    logic [FW-1:0]      fill_reg;
    logic [FW-1:0]      i_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic               in_win_reg;
    counts_t            c_reg;

    // memory read and write
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            ent_reg <= ring_mem[rd_idx_reg];
        end
        if (state_reg == S_STORE) begin
            ring_mem[wp_reg] <= cur_reg;
        end
    end

    // per-entry compares
    logic same_host, same_srv, se, re, win_now;
    logic [32:0] tsum;
    always_comb begin
        same_host = ent_reg.dest_ip == cur_reg.dest_ip;
        same_srv  = ent_reg.service_id == cur_reg.service_id;
        se        = (ent_reg.flag_code >= FLAG_S0) && (ent_reg.flag_code <= FLAG_S3);
        re        = ent_reg.flag_code == FLAG_REJ;
        tsum      = {1'b0, ent_reg.timestamp} + {1'b0, window_length};
        win_now   = in_win_reg && !(tsum < {1'b0, cur_reg.timestamp});
    end

    assign rec_ready = state_reg == S_IDLE;
    assign cnt_valid = state_reg == S_HOLD;
    assign cnt_out   = c_reg;

    // scan sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (rec_valid) begin
                        cur_reg    <= rec;
                        c_reg      <= '0;
                        i_reg      <= '0;
                        in_win_reg <= 1'b1;
                        rd_idx_reg <= (wp_reg == '0) ? AW'(DEPTH - 1) : wp_reg - AW'(1);
                        state_reg  <= (fill_reg == '0) ? S_STORE : S_READ;
                    end
                end
                S_READ: begin
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    in_win_reg <= win_now;
                    if (win_now && same_host) begin
                        c_reg.cnt  <= c_reg.cnt + 11'd1;
                        c_reg.c_se <= c_reg.c_se + 11'(se);
                        c_reg.c_re <= c_reg.c_re + 11'(re);
                        c_reg.host_srv <= c_reg.host_srv + 11'(same_srv);
                    end
                    if (win_now && same_srv) begin
                        c_reg.srv  <= c_reg.srv + 11'd1;
                        c_reg.s_se <= c_reg.s_se + 11'(se);
                        c_reg.s_re <= c_reg.s_re + 11'(re);
                        c_reg.srv_diff <= c_reg.srv_diff + 11'(!same_host);
                    end
                    if (same_host) begin
                        c_reg.h_cnt  <= c_reg.h_cnt + 11'd1;
                        c_reg.h_port <= c_reg.h_port
                                      + 11'(ent_reg.source_port == cur_reg.source_port);
                        c_reg.h_se   <= c_reg.h_se + 11'(se);
                        c_reg.h_re   <= c_reg.h_re + 11'(re);
                        if (same_srv) begin
                            c_reg.h_srv  <= c_reg.h_srv + 11'd1;
                            c_reg.h_diff <= c_reg.h_diff
                                          + 11'(ent_reg.source_ip != cur_reg.source_ip);
                            c_reg.hs_se  <= c_reg.hs_se + 11'(se);
                            c_reg.hs_re  <= c_reg.hs_re + 11'(re);
                        end
                    end
                    i_reg      <= i_reg + FW'(1);
                    rd_idx_reg <= (rd_idx_reg == '0) ? AW'(DEPTH - 1)
                                                     : rd_idx_reg - AW'(1);
                    state_reg  <= (i_reg + FW'(1) == fill_reg) ? S_STORE : S_READ;
                end
                S_STORE: begin
                    wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    if (fill_reg != FW'(DEPTH)) begin
                        fill_reg <= fill_reg + FW'(1);
                    end
                    state_reg <= S_HOLD;
                end
                S_HOLD: begin
                    if (cnt_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/cwfe_queue.sv]
// two-entry queue of counter sets between scan and feature emit
`timescale 1ns / 1ps
module cwfe_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cwfe_pkg::counts_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cwfe_pkg::counts_t out_data
);
    import cwfe_pkg::*;

    counts_t    slot_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] num_reg;

    assign in_ready  = num_reg != 2'd2;
    assign out_valid = num_reg != 2'd0;
    assign out_data  = slot_reg[rd_reg];

    // storage and pointers
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            slot_reg[wr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            num_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wr_reg <= !wr_reg;
            if (out_valid && out_ready) rd_reg <= !rd_reg;
            num_reg <= num_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end

endmodule

[hw/rtl/cwfe_emit.sv]
// back part: serial divider for the rates and output register for the nineteen features
`timescale 1ns / 1ps
module cwfe_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cnt_valid,
    output logic              cnt_ready,
    input  cwfe_pkg::counts_t cnt_in,
    output logic              m_valid,
    input  logic              m_ready,
    output cwfe_pkg::feat_t   m_data
);
    import cwfe_pkg::*;

    typedef enum logic [1:0] {E_IDLE, E_SETUP, E_DIV, E_OUT} state_t;

    state_t      state_reg;
    counts_t     c_reg;
    logic [4:0]  idx_reg;
    logic [25:0] num_reg;   // numerator shifted by 15
    logic [10:0] den_reg;
    logic [11:0] rem_reg;
    logic [25:0] quo_reg;
    logic [4:0]  bit_reg;
    logic        diff_reg;
    feat_t       out_reg;

    // numerator and denominator per feature
    logic [10:0] num_sel, den_sel;
    logic        is_rate, is_diff;
    always_comb begin
        num_sel = '0;
        den_sel = '0;
        is_rate = 1'b1;
        is_diff = 1'b0;
        case (idx_reg)
            5'd0:  begin num_sel = c_reg.cnt;      is_rate = 1'b0; end
            5'd1:  begin num_sel = c_reg.srv;      is_rate = 1'b0; end
            5'd2:  begin num_sel = c_reg.c_se;     den_sel = c_reg.cnt;   end
            5'd3:  begin num_sel = c_reg.s_se;     den_sel = c_reg.srv;   end
            5'd4:  begin num_sel = c_reg.c_re;     den_sel = c_reg.cnt;   end
            5'd5:  begin num_sel = c_reg.s_re;     den_sel = c_reg.srv;   end
            5'd6:  begin num_sel = c_reg.host_srv; den_sel = c_reg.cnt;   end
            5'd7:  begin num_sel = c_reg.host_srv; den_sel = c_reg.cnt; is_diff = 1'b1; end
            5'd8:  begin num_sel = c_reg.srv_diff; den_sel = c_reg.srv;   end
            5'd9:  begin num_sel = c_reg.h_cnt;    is_rate = 1'b0; end
            5'd10: begin num_sel = c_reg.h_srv;    is_rate = 1'b0; end
            5'd11: begin num_sel = c_reg.h_srv;    den_sel = c_reg.h_cnt; end
            5'd12: begin num_sel = c_reg.h_srv;    den_sel = c_reg.h_cnt; is_diff = 1'b1; end
            5'd13: begin num_sel = c_reg.h_port;   den_sel = c_reg.h_cnt; end
            5'd14: begin num_sel = c_reg.h_diff;   den_sel = c_reg.h_srv; end
            5'd15: begin num_sel = c_reg.h_se;     den_sel = c_reg.h_cnt; end
            5'd16: begin num_sel = c_reg.hs_se;    den_sel = c_reg.h_srv; end
            5'd17: begin num_sel = c_reg.h_re;     den_sel = c_reg.h_cnt; end
            5'd18: begin num_sel = c_reg.hs_re;    den_sel = c_reg.h_srv; end
            default: begin num_sel = '0; den_sel = '0; end
        endcase
    end

    // one restoring step
    logic [11:0] rem_sh;
    logic [12:0] trial;
    always_comb begin
        rem_sh   = {rem_reg[10:0], num_reg[25]};
        trial    = {1'b0, rem_sh} - {2'b0, den_reg};
    end

    assign cnt_ready = state_reg == E_IDLE;
    assign m_valid   = state_reg == E_OUT;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
        end else begin
            case (state_reg)
                E_IDLE: begin
                    if (cnt_valid) begin
                        c_reg     <= cnt_in;
                        idx_reg   <= '0;
                        state_reg <= E_SETUP;
                    end
                end
                E_SETUP: begin
                    num_reg  <= {num_sel, 15'd0};
                    den_reg  <= den_sel;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    bit_reg  <= 5'd0;
                    diff_reg <= is_diff;
                    if (is_rate) begin
                        state_reg <= E_DIV;
                    end else begin
                        out_reg.feature_index <= idx_reg;
                        out_reg.feature_value <= {5'd0, num_sel};
                        out_reg.last          <= idx_reg == 5'(FEATURE_COUNT - 1);
                        state_reg             <= E_OUT;
                    end
                end
                E_DIV: begin
                    num_reg <= {num_reg[24:0], 1'b0};
                    if (!trial[12]) begin
                        rem_reg <= trial[11:0];
                        quo_reg <= {quo_reg[24:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[24:0], 1'b0};
                    end
                    bit_reg <= bit_reg + 5'd1;
                    if (bit_reg == 5'd25) begin
                        state_reg <= E_OUT;
                    end
                end
                E_OUT: begin
                    if (m_ready) begin
                        idx_reg   <= idx_reg + 5'd1;
                        state_reg <= (idx_reg == 5'(FEATURE_COUNT - 1)) ? E_IDLE : E_SETUP;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
            // rate result lands once the last quotient bit is in
            if (state_reg == E_DIV && bit_reg == 5'd25) begin
                out_reg.feature_index <= idx_reg;
                out_reg.last          <= idx_reg == 5'(FEATURE_COUNT - 1);
                out_reg.feature_value <= diff_reg
                    ? 16'(Q_ONE - ((den_reg == '0) ? 17'd0
                        : {1'b0, quo_reg[14:0], !trial[12]}))
                    : ((den_reg == '0) ? 16'd0 : {quo_reg[14:0], !trial[12]});
            end
        end
    end

endmodule

[hw/rtl/connection_window_feature_extractor_unit.sv]
// top level of the connection window feature extractor
`timescale 1ns / 1ps
// Takes one connection record per item and returns nineteen feature items
// (index 0..18, last set on 18) computed against up to DEPTH previous records.
// The scan unit reads the record ring newest entry first, with a read state
// and an accumulate state per entry; the emit unit runs a one-bit-per-
// cycle restoring divider for each rate and passes the counts through as they
// are. A two-entry queue lets the scan of the next record
// overlap the emission of the previous one; the emit side sets the rate.
// window_length may be written only while the block is idle.
module connection_window_feature_extractor_unit #(
    parameter int unsigned DEPTH = cwfe_pkg::DEPTH_DEFAULT
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [31:0]     cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  cwfe_pkg::rec_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output cwfe_pkg::feat_t m_data
);
    import cwfe_pkg::*;

    logic [31:0] window_reg;
    logic        sc_valid, sc_ready, q_valid, q_ready;
    counts_t     sc_data, q_data;

    // window length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_we) begin
            window_reg <= cfg_wdata;
        end
    end

    cwfe_scan #(.DEPTH(DEPTH)) u_scan (
        .aclk, .aresetn, .window_length(window_reg),
        .rec_valid(s_valid), .rec_ready(s_ready), .rec(s_data),
        .cnt_valid(sc_valid), .cnt_ready(sc_ready), .cnt_out(sc_data)
    );

    cwfe_queue u_queue (
        .aclk, .aresetn,
        .in_valid(sc_valid), .in_ready(sc_ready), .in_data(sc_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    cwfe_emit u_emit (
        .aclk, .aresetn,
        .cnt_valid(q_valid), .cnt_ready(q_ready), .cnt_in(q_data),
        .m_valid, .m_ready, .m_data
    );

    // index only advances on an accepted item
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    // last marks feature 18 only
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == (m_data.feature_index == 5'd18)))
        else $error("last flag on wrong feature");
    // rates never exceed one
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.feature_index != 5'd0 && m_data.feature_index != 5'd1
        && m_data.feature_index != 5'd9 && m_data.feature_index != 5'd10
        |-> m_data.feature_value <= 16'd32768)
        else $error("rate above one");

endmodule

[bench/tb_connection_window_feature_extractor_unit.sv]
// testbench for the connection window feature extractor top level
`timescale 1ns / 1ps
module tb_connection_window_feature_extractor_unit;
    import cwfe_pkg::*;

    localparam int RING = 128;
    localparam int REPORT_LIMIT = 10;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    rec_t        s_data;
    logic        m_valid;
    logic        m_ready;
    feat_t       m_data;

    connection_window_feature_extractor_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // shadow of the record ring and the window register
    logic [31:0] ring_time [RING];
    logic [31:0] ring_sip [RING];
    logic [31:0] ring_dip [RING];
    logic [15:0] ring_sport [RING];
    logic [7:0]  ring_svc [RING];
    logic [3:0]  ring_flag [RING];
    int          ring_wr;
    int          ring_fill;
    logic [31:0] span_ticks;

    feat_t expected_feats [$];
    int    mismatch_count;
    int    sender_gap_off;
    int    receiver_gap_off;
    int    receiver_hold;
    logic [31:0] now_ticks;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // hard limit on run time
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [15:0] q15(input int unsigned num, input int unsigned den);
        longint unsigned wide;
        if (den == 0) return 16'd0;
        wide = (longint'(num) << 15) / den;
        return wide[15:0];
    endfunction

    function automatic logic is_syn_err(input logic [3:0] f);
        return f >= FLAG_S0 && f <= FLAG_S3;
    endfunction

    // compute the nineteen features of a record, then store it in the ring
    task automatic predict_features(input rec_t r);
        int unsigned cnt, srv, host_srv, srv_diff, c_se, c_re, s_se, s_re;
        int unsigned h_cnt, h_srv, h_port, h_diff, h_se, h_re, hs_se, hs_re;
        logic [15:0] fv [FEATURE_COUNT];
        logic        open_win;
        logic        same_host, same_svc, syn, rej;
        int          idx;
        feat_t       ft;
        cnt = 0; srv = 0; host_srv = 0; srv_diff = 0;
        c_se = 0; c_re = 0; s_se = 0; s_re = 0;
        h_cnt = 0; h_srv = 0; h_port = 0; h_diff = 0;
        h_se = 0; h_re = 0; hs_se = 0; hs_re = 0;
        open_win = 1'b1;
        for (int i = 0; i < ring_fill; i++) begin
            idx = (ring_wr + RING - 1 - i) % RING;
            same_host = ring_dip[idx] == r.dest_ip;
            same_svc  = ring_svc[idx] == r.service_id;
            syn = is_syn_err(ring_flag[idx]);
            rej = ring_flag[idx] == FLAG_REJ;
            if (open_win && ({1'b0, ring_time[idx]} + {1'b0, span_ticks}) <
                    {1'b0, r.timestamp})
                open_win = 1'b0;
            if (open_win) begin
                if (same_host) begin
                    cnt++;
                    c_se += syn;
                    c_re += rej;
                    host_srv += same_svc;
                end
                if (same_svc) begin
                    srv++;
                    s_se += syn;
                    s_re += rej;
                    srv_diff += !same_host;
                end
            end
            if (same_host) begin
                h_cnt++;
                h_port += ring_sport[idx] == r.source_port;
                h_se += syn;
                h_re += rej;
                if (same_svc) begin
                    h_srv++;
                    h_diff += ring_sip[idx] != r.source_ip;
                    hs_se += syn;
                    hs_re += rej;
                end
            end
        end
        fv[0]  = cnt[15:0];
        fv[1]  = srv[15:0];
        fv[2]  = q15(c_se, cnt);
        fv[3]  = q15(s_se, srv);
        fv[4]  = q15(c_re, cnt);
        fv[5]  = q15(s_re, srv);
        fv[6]  = q15(host_srv, cnt);
        fv[7]  = 16'd32768 - fv[6];
        fv[8]  = q15(srv_diff, srv);
        fv[9]  = h_cnt[15:0];
        fv[10] = h_srv[15:0];
        fv[11] = q15(h_srv, h_cnt);
        fv[12] = 16'd32768 - fv[11];
        fv[13] = q15(h_port, h_cnt);
        fv[14] = q15(h_diff, h_srv);
        fv[15] = q15(h_se, h_cnt);
        fv[16] = q15(hs_se, h_srv);
        fv[17] = q15(h_re, h_cnt);
        fv[18] = q15(hs_re, h_srv);
        ring_time[ring_wr]  = r.timestamp;
        ring_sip[ring_wr]   = r.source_ip;
        ring_dip[ring_wr]   = r.dest_ip;
        ring_sport[ring_wr] = r.source_port;
        ring_svc[ring_wr]   = r.service_id;
        ring_flag[ring_wr]  = r.flag_code;
        ring_wr = (ring_wr + 1) % RING;
        if (ring_fill < RING) ring_fill++;
        for (int k = 0; k < FEATURE_COUNT; k++) begin
            ft.feature_index = k[4:0];
            ft.feature_value = fv[k];
            ft.last = (k == FEATURE_COUNT - 1);
            expected_feats.push_back(ft);
        end
    endtask

    // offer one record and wait until it is taken
    task automatic send_record(input rec_t r);
        int gap;
        gap = sender_gap_off ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        predict_features(r);
    endtask

    // drain, let the block settle, then write the window length
    task automatic set_window(input logic [31:0] v);
        s_valid <= 1'b0;
        while (expected_feats.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        span_ticks = v;
    endtask

    function automatic rec_t make_rec(input logic [31:0] ts, input logic [31:0] sip,
            input logic [31:0] dip, input logic [15:0] sport,
            input logic [7:0] svc, input logic [3:0] flg);
        rec_t r;
        r.timestamp = ts; r.source_ip = sip; r.dest_ip = dip;
        r.source_port = sport; r.service_id = svc; r.flag_code = flg;
        return r;
    endfunction

    // mostly well-formed traffic over small pools, some full-range noise
    function automatic rec_t traffic_rec(input int unsigned step_max);
        logic [31:0] dips [4] = '{32'h0A000001, 32'h0A000002, 32'hFFFFFFFF, 32'h0};
        logic [31:0] sips [3] = '{32'hC0A80001, 32'hC0A80002, 32'h5555AAAA};
        logic [7:0]  svcs [3] = '{8'd0, 8'd21, 8'd255};
        rec_t r;
        if ($urandom_range(0, 9) == 0) begin
            r.timestamp   = now_ticks + $urandom_range(0, step_max);
            r.source_ip   = $urandom;
            r.dest_ip     = $urandom;
            r.source_port = 16'($urandom);
            r.service_id  = 8'($urandom);
            r.flag_code   = 4'($urandom);
            if ($urandom_range(0, 3) == 0) r.timestamp = $urandom;
        end else begin
            r.timestamp   = now_ticks + $urandom_range(0, step_max);
            r.source_ip   = sips[$urandom_range(0, 2)];
            r.dest_ip     = dips[$urandom_range(0, 3)];
            r.source_port = $urandom_range(0, 1) ? 16'd80 : 16'hFFFF;
            r.service_id  = svcs[$urandom_range(0, 2)];
            r.flag_code   = 4'($urandom_range(0, 15));
        end
        now_ticks = r.timestamp;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        feat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_feats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected item idx=%0d val=%0d last=%b",
                        m_data.feature_index, m_data.feature_value, m_data.last);
            end else begin
                want = expected_feats.pop_front();
                if (m_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: exp idx=%0d val=%0d last=%b,",
                                  " got idx=%0d val=%0d last=%b"},
                            want.feature_index, want.feature_value, want.last,
                            m_data.feature_index, m_data.feature_value, m_data.last);
                end
            end
        end
    end

    // result receiver with random stalls and long holds on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (receiver_hold > 0) begin
                gap = receiver_hold;
                receiver_hold = 0;
            end else begin
                gap = receiver_gap_off ? 0 : $urandom_range(0, 7);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // empty ring, flags, window edges, backward time, field extremes
    task automatic test_directed_cases();
        send_record(make_rec(32'd1000, 32'h0, 32'h0A000001, 16'd0, 8'd0, 4'd9));
        for (int f = 0; f < 16; f++)
            send_record(make_rec(32'd1000 + f, 32'hC0A80001 + f[0], 32'h0A000001,
                16'd80, 8'd21, f[3:0]));
        // entry at exactly the window edge stays, sixteen ticks past the edge it falls out
        send_record(make_rec(32'd3000, 32'h1, 32'h0A000001, 16'd80, 8'd21, 4'd5));
        send_record(make_rec(32'd5016, 32'h1, 32'h0A000001, 16'd80, 8'd21, 4'd1));
        // timestamp going backwards
        send_record(make_rec(32'd10, 32'h2, 32'h0A000001, 16'd80, 8'd0, 4'd6));
        send_record(make_rec(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF,
            8'hFF, 4'hF));
        send_record(make_rec(32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 16'hFFFF,
            8'hFF, 4'd7));
        now_ticks = 32'd6000;
    endtask

    // zero and maximum window lengths, sum carrying past 32 bits
    task automatic test_window_extremes();
        set_window(32'd0);
        send_record(make_rec(32'd6000, 32'h3, 32'h0A000001, 16'd80, 8'd21, 4'd8));
        send_record(make_rec(32'd6000, 32'h4, 32'h0A000001, 16'd80, 8'd21, 4'd1));
        send_record(make_rec(32'd6001, 32'h3, 32'h0A000001, 16'd81, 8'd21, 4'd0));
        set_window(32'hFFFFFFFF);
        send_record(make_rec(32'hF0000000, 32'h3, 32'h0A000002, 16'd80, 8'd0, 4'd5));
        send_record(make_rec(32'hFFFFFFFF, 32'h3, 32'h0A000002, 16'd80, 8'd0, 4'd1));
        now_ticks = 32'd7000;
    endtask

    // random traffic over several window settings, past ring wrap
    task automatic test_random_traffic();
        logic [31:0] spans [4] = '{32'd2000, 32'd50, 32'd1, 32'd100000};
        for (int p = 0; p < 4; p++) begin
            set_window(spans[p]);
            sender_gap_off   = (p == 1);
            receiver_gap_off = (p == 2);
            for (int n = 0; n < 110; n++) send_record(traffic_rec(spans[p] / 8 + 2));
        end
        sender_gap_off   = 0;
        receiver_gap_off = 0;
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        set_window(32'd500);
        receiver_hold = 3000;
        sender_gap_off = 1;
        for (int n = 0; n < 8; n++) send_record(traffic_rec(100));
        sender_gap_off = 0;
    endtask

    // stimulus
    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        ring_wr = 0;
        ring_fill = 0;
        span_ticks = WINDOW_RESET;
        mismatch_count = 0;
        sender_gap_off = 0;
        receiver_gap_off = 0;
        receiver_hold = 0;
        now_ticks = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_window_extremes();
        test_random_traffic();
        test_output_backpressure();
        s_valid <= 1'b0;
        while (expected_feats.size() != 0) @(posedge aclk);
        repeat (500) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
